>>> design/ccmts_pkg.sv
// Package for the character-class Markov trainer and sampler.
// Holds the item types, the mode, class and distribution codes, and the letter tables.
// Depends on nothing; used by char_class_markov_trainer_sampler_unit.
`default_nettype none
package ccmts_pkg;

   typedef enum logic [1:0] {
      MODE_TRAIN = 2'd0,
      MODE_START = 2'd1,
      MODE_NEXT  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CLS_CONSONANT = 2'd0,
      CLS_VOWEL     = 2'd1,
      CLS_SPACE     = 2'd2,
      CLS_OTHER     = 2'd3
   } class_type;

   // Which distribution the sampler walks.
   typedef enum logic [2:0] {
      DK_LETTERS = 3'd0,
      DK_CONS    = 3'd1,
      DK_VOWEL   = 3'd2,
      DK_SPACE   = 3'd3,
      DK_SPECIAL = 3'd4,
      DK_TRANS   = 3'd5
   } dist_type;

   localparam logic [4:0] BIN_SPACE   = 5'd26;
   localparam logic [4:0] BIN_SPECIAL = 5'd27;
   localparam logic [5:0] IDX_TRANS   = 6'd28;
   localparam logic [5:0] IDX_CTOTAL  = 6'd44;
   localparam logic [5:0] IDX_TTOTAL  = 6'd45;
   localparam logic [7:0] CHAR_A      = 8'd97;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_HASH   = 8'd35;

   localparam logic [4:0] VOWEL_BINS [6] = '{5'd0, 5'd4, 5'd8, 5'd14, 5'd20, 5'd24};
   localparam logic [4:0] CONS_BINS [20] = '{
      5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd21, 5'd22, 5'd23, 5'd25};

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  char_byte;
      logic [15:0] rand_a;
      logic [15:0] rand_b;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      class_type   char_class;
      logic [31:0] count_value;
      logic        empty_distribution;
   } rsp_type;

   function automatic logic bin_is_vowel(input logic [4:0] bin);
      logic v;
      v = 1'b0;
      for (int i = 0; i < 6; i++)
         if (VOWEL_BINS[i] == bin) v = 1'b1;
      return v;
   endfunction

   function automatic logic [4:0] dist_len(input dist_type dk);
      logic [4:0] n;
      case (dk)
         DK_LETTERS: n = 5'd26;
         DK_CONS:    n = 5'd20;
         DK_VOWEL:   n = 5'd6;
         DK_TRANS:   n = 5'd4;
         default:    n = 5'd1;
      endcase
      return n;
   endfunction

   // Counter index (read_index numbering) of entry i of a distribution.
   function automatic logic [5:0] dist_addr(input dist_type dk, input logic [4:0] i,
                                            input class_type g);
      logic [5:0] a;
      case (dk)
         DK_LETTERS: a = {1'b0, i};
         DK_CONS:    a = {1'b0, CONS_BINS[i]};
         DK_VOWEL:   a = {1'b0, VOWEL_BINS[i[2:0]]};
         DK_SPACE:   a = {1'b0, BIN_SPACE};
         DK_SPECIAL: a = {1'b0, BIN_SPECIAL};
         DK_TRANS:   a = IDX_TRANS + {2'b00, g, i[1:0]};
         default:    a = 6'd0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

>>> design/char_class_markov_trainer_sampler_unit.sv
// Train and read items: counted or read on acceptance, then delivered from the output state.
// Start item: one pass totals the letter counts, a second scans them, then delivery.
// Next item: a total and a scan of the class row, then of the chosen consonant, vowel,
// space or special distribution, then delivery; all on the one shared accumulate unit.
// One item at a time; req_ready is high only while the sequencer is idle.
// Synchronous active-high reset clears every counter, the class history and the handshake.
`default_nettype none
module char_class_markov_trainer_sampler_unit
   import ccmts_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // A sum of up to 26 counters needs five more bits; the scaled compare
   // works on that sum times a 16-bit random fraction.
   localparam int SUMW = COUNT_WIDTH + 5;
   localparam int RTW  = SUMW + 16;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SUM  = 4'b0010,
      S_SCAN = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   logic [COUNT_WIDTH-1:0] char_ff [28];
   logic [COUNT_WIDTH-1:0] char_in [28];
   logic [COUNT_WIDTH-1:0] trans_ff [16];
   logic [COUNT_WIDTH-1:0] trans_in [16];
   logic [COUNT_WIDTH-1:0] ctot_ff, ctot_in, ttot_ff, ttot_in;
   class_type  prev_ff, prev_in, gen_ff, gen_in, cls_ff, cls_in;
   logic       pvalid_ff, pvalid_in;
   state_type  state_ff, state_in;
   dist_type   dk_ff, dk_in;
   logic [4:0] idx_ff, idx_in;
   logic [15:0] rnd_ff, rnd_in, rb_ff, rb_in;
   logic [SUMW-1:0] tot_ff, tot_in, cum_ff, cum_in;
   logic [RTW-1:0]  rt_ff, rt_in;
   logic       empty_ff, empty_in;
   rsp_type    res_ff, res_in, rsp_ff, rsp_in;
   logic       rspv_ff, rspv_in;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // One counter, addressed the way read mode numbers them.
   function automatic logic [COUNT_WIDTH-1:0] read_cnt(
      input logic [5:0] a,
      input logic [COUNT_WIDTH-1:0] ch [28],
      input logic [COUNT_WIDTH-1:0] tr [16],
      input logic [COUNT_WIDTH-1:0] ct,
      input logic [COUNT_WIDTH-1:0] tt);
      logic [COUNT_WIDTH-1:0] v;
      logic [5:0] t;
      t = a - IDX_TRANS;
      if (a < IDX_TRANS)        v = ch[a[4:0]];
      else if (a < IDX_CTOTAL)  v = tr[t[3:0]];
      else if (a == IDX_CTOTAL) v = ct;
      else if (a == IDX_TTOTAL) v = tt;
      else                      v = '0;
      return v;
   endfunction

   function automatic logic [31:0] to32(input logic [COUNT_WIDTH-1:0] v);
      logic [47:0] w;
      w = 48'(v);
      return w[31:0];
   endfunction

   // Shared unit signals: the entry under the cursor and its running sums.
   logic [5:0]             addr;
   logic [COUNT_WIDTH-1:0] val;
   logic [4:0]             len;
   logic                   last;
   logic [SUMW-1:0]        tot_nx, cum_nx;
   logic [COUNT_WIDTH+15:0] prod;
   logic [RTW-1:0]         rt_nx, cum_scaled;
   logic                   hit;

   // Train decode.
   logic [7:0] lc;
   logic [4:0] tbin;
   class_type  tcls;
   logic [3:0] tidx;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      addr = dist_addr(dk_ff, idx_ff, gen_ff);
      val  = read_cnt(addr, char_ff, trans_ff, ctot_ff, ttot_ff);
      len  = dist_len(dk_ff);
      last = (idx_ff == len - 5'd1);
      tot_nx = tot_ff + SUMW'(val);
      // Full-width product of the entry and the random fraction.
      prod   = {16'h0000, val} * {{COUNT_WIDTH{1'b0}}, rnd_ff};
      rt_nx  = rt_ff + RTW'(prod);
      cum_nx = cum_ff + SUMW'(val);
      // cum * 65535 written as cum * 65536 - cum.
      cum_scaled = {cum_nx, 16'h0000} - RTW'(cum_nx);
      hit = (cum_scaled >= rt_ff);

      lc = ((req_data.char_byte >= 8'd65) && (req_data.char_byte <= 8'd90)) ?
           req_data.char_byte + 8'd32 : req_data.char_byte;
      if ((lc >= CHAR_A) && (lc <= 8'd122)) begin
         tbin = 5'(lc - CHAR_A);
         tcls = bin_is_vowel(tbin) ? CLS_VOWEL : CLS_CONSONANT;
      end else if ((req_data.char_byte == CHAR_SPACE) ||
                   ((req_data.char_byte >= 8'd9) && (req_data.char_byte <= 8'd13))) begin
         tbin = BIN_SPACE;
         tcls = CLS_SPACE;
      end else begin
         tbin = BIN_SPECIAL;
         tcls = CLS_OTHER;
      end
      tidx = {prev_ff, tcls};
   end

   // Sequencer.
   always_comb begin
      char_in   = char_ff;
      trans_in  = trans_ff;
      ctot_in   = ctot_ff;
      ttot_in   = ttot_ff;
      prev_in   = prev_ff;
      pvalid_in = pvalid_ff;
      gen_in    = gen_ff;
      cls_in    = cls_ff;
      state_in  = state_ff;
      dk_in     = dk_ff;
      idx_in    = idx_ff;
      rnd_in    = rnd_ff;
      rb_in     = rb_ff;
      tot_in    = tot_ff;
      cum_in    = cum_ff;
      rt_in     = rt_ff;
      empty_in  = empty_ff;
      res_in    = res_ff;
      rsp_in    = rsp_ff;
      rspv_in   = rspv_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               empty_in = 1'b0;
               idx_in   = '0;
               tot_in   = '0;
               rt_in    = '0;
               rnd_in   = req_data.rand_a;
               rb_in    = req_data.rand_b;
               case (req_data.mode)
                  MODE_TRAIN: begin
                     if (pvalid_ff) begin
                        trans_in[tidx] = sat_inc(trans_ff[tidx]);
                        ttot_in = sat_inc(ttot_ff);
                     end
                     char_in[tbin] = sat_inc(char_ff[tbin]);
                     ctot_in   = sat_inc(ctot_ff);
                     prev_in   = tcls;
                     pvalid_in = 1'b1;
                     res_in.char_class = tcls;
                     state_in  = S_OUT;
                  end
                  MODE_START: begin
                     dk_in    = DK_LETTERS;
                     state_in = S_SUM;
                  end
                  MODE_NEXT: begin
                     dk_in    = DK_TRANS;
                     state_in = S_SUM;
                  end
                  MODE_READ: begin
                     res_in.count_value = to32(read_cnt(req_data.read_index, char_ff,
                                                        trans_ff, ctot_ff, ttot_ff));
                     state_in = S_OUT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SUM: begin
            // First pass: total and total times random, one entry a cycle.
            tot_in = tot_nx;
            rt_in  = rt_nx;
            idx_in = idx_ff + 5'd1;
            if (last) begin
               cum_in = '0;
               idx_in = '0;
               state_in = S_SCAN;
               if (tot_nx == '0) begin
                  // Empty distribution: take the last entry straight away.
                  empty_in = 1'b1;
                  idx_in   = idx_ff;
               end
            end
         end
         S_SCAN: begin
            cum_in = cum_nx;
            idx_in = idx_ff + 5'd1;
            if (hit || last || empty_ff && (tot_ff == '0)) begin
               idx_in = '0;
               tot_in = '0;
               rt_in  = '0;
               case (dk_ff)
                  DK_LETTERS: begin
                     gen_in = bin_is_vowel(idx_ff) ? CLS_VOWEL : CLS_CONSONANT;
                     res_in.out_char   = CHAR_A + 8'(idx_ff);
                     res_in.char_class = gen_in;
                     state_in = S_OUT;
                  end
                  DK_TRANS: begin
                     // Chosen class picks the letter distribution; second random.
                     cls_in = class_type'(idx_ff[1:0]);
                     gen_in = class_type'(idx_ff[1:0]);
                     rnd_in = rb_ff;
                     case (class_type'(idx_ff[1:0]))
                        CLS_CONSONANT: dk_in = DK_CONS;
                        CLS_VOWEL:     dk_in = DK_VOWEL;
                        CLS_SPACE:     dk_in = DK_SPACE;
                        default:       dk_in = DK_SPECIAL;
                     endcase
                     state_in = S_SUM;
                  end
                  DK_SPACE: begin
                     res_in.out_char   = CHAR_SPACE;
                     res_in.char_class = cls_ff;
                     state_in = S_OUT;
                  end
                  DK_SPECIAL: begin
                     res_in.out_char   = CHAR_HASH;
                     res_in.char_class = cls_ff;
                     state_in = S_OUT;
                  end
                  default: begin
                     res_in.out_char   = CHAR_A + 8'(addr[4:0]);
                     res_in.char_class = cls_ff;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (!rspv_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_in.empty_distribution = empty_ff;
               rspv_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 28; i++) char_ff[i] <= '0;
         for (int i = 0; i < 16; i++) trans_ff[i] <= '0;
         ctot_ff   <= '0;
         ttot_ff   <= '0;
         prev_ff   <= CLS_CONSONANT;
         pvalid_ff <= 1'b0;
         gen_ff    <= CLS_CONSONANT;
         state_ff  <= S_IDLE;
         rspv_ff   <= 1'b0;
      end else begin
         char_ff   <= char_in;
         trans_ff  <= trans_in;
         ctot_ff   <= ctot_in;
         ttot_ff   <= ttot_in;
         prev_ff   <= prev_in;
         pvalid_ff <= pvalid_in;
         gen_ff    <= gen_in;
         state_ff  <= state_in;
         rspv_ff   <= rspv_in;
      end
      cls_ff   <= cls_in;
      dk_ff    <= dk_in;
      idx_ff   <= idx_in;
      rnd_ff   <= rnd_in;
      rb_ff    <= rb_in;
      tot_ff   <= tot_in;
      cum_ff   <= cum_in;
      rt_ff    <= rt_in;
      empty_ff <= empty_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff < len))
      else $error("scan cursor beyond distribution");
   a_train_counts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.mode == MODE_TRAIN)) |=> (ctot_ff != '0))
      else $error("character total zero after training");
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !empty_ff) |-> (tot_ff != '0))
      else $error("scan started on empty total");
   a_out_then_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rspv_ff || rsp_ready)) |=> (rspv_ff && state_ff == S_IDLE))
      else $error("result not delivered");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for the character-class Markov trainer and sampler unit.
// Drives train, start, next and read items and checks every result against an
// internal predictor. Depends on ccmts_pkg and char_class_markov_trainer_sampler_unit.
`default_nettype none

class markov_scoreboard;
   ccmts_pkg::rsp_type pending_rsps[$];
   int unsigned mismatch_count;
   int unsigned checked_count;

   function new();
      mismatch_count = 0;
      checked_count = 0;
   endfunction

   function void note_request(ccmts_pkg::rsp_type predicted);
      pending_rsps.push_back(predicted);
   endfunction

   function void check_response(ccmts_pkg::rsp_type actual);
      ccmts_pkg::rsp_type want;
      if (pending_rsps.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: unexpected result %h", actual);
         return;
      end
      want = pending_rsps.pop_front();
      checked_count++;
      if (want.out_char !== actual.out_char || want.char_class !== actual.char_class ||
          want.count_value !== actual.count_value ||
          want.empty_distribution !== actual.empty_distribution) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"ERROR: result %0d: expected char=%h class=%0d count=%h empty=%b,",
                      " got char=%h class=%0d count=%h empty=%b"},
                     checked_count, want.out_char, want.char_class, want.count_value,
                     want.empty_distribution, actual.out_char, actual.char_class,
                     actual.count_value, actual.empty_distribution);
      end
   endfunction
endclass

module tb;
   import ccmts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Percent chance per cycle that the sender or the receiver sits idle.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned cycle_count;
   int unsigned items_sent;

   markov_scoreboard board;

   // Predictor state, a private copy of the block's counters.
   logic [31:0] letter_bins[28];
   logic [31:0] class_pairs[16];
   logic [31:0] letters_seen;
   logic [31:0] pairs_seen;
   class_type   last_trained;
   logic        have_last;
   class_type   walk_class;

   char_class_markov_trainer_sampler_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Timeout watchdog counting clock cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The receiver drops ready at random; each accepted result goes to the scoreboard.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] saturating_bump(logic [31:0] c);
      return (c == COUNT_MAX) ? c : c + 32'd1;
   endfunction

   function automatic logic letter_is_vowel(int bin);
      return bin == 0 || bin == 4 || bin == 8 || bin == 14 || bin == 20 || bin == 24;
   endfunction

   // Walks a list of counts and returns the first entry whose running sum times 65535
   // reaches rnd times the sum. An all-zero list, or no entry reaching it, gives the last.
   function automatic int pick_entry(logic [31:0] counts[$], logic [15:0] rnd,
                                     ref logic empty);
      logic [63:0] sum;
      logic [63:0] running;
      sum = 64'd0;
      running = 64'd0;
      foreach (counts[i]) sum += counts[i];
      if (sum == 0) begin
         empty = 1'b1;
         return counts.size() - 1;
      end
      foreach (counts[i]) begin
         running += counts[i];
         if ({16'd0, running} * 80'd65535 >= {16'd0, sum} * {64'd0, rnd}) return i;
      end
      return counts.size() - 1;
   endfunction

   function automatic rsp_type predict_item(req_type r);
      rsp_type     res;
      logic [31:0] row[$];
      logic [7:0]  lc;
      int          bin;
      int          k;
      class_type   cls;
      logic        empty;
      res = '0;
      empty = 1'b0;
      case (r.mode)
         MODE_TRAIN: begin
            lc = (r.char_byte >= "A" && r.char_byte <= "Z") ? r.char_byte + 8'd32
                                                           : r.char_byte;
            if (lc >= "a" && lc <= "z") begin
               bin = lc - "a";
               cls = letter_is_vowel(bin) ? CLS_VOWEL : CLS_CONSONANT;
            end else if (r.char_byte == 8'd32 || (r.char_byte >= 8'd9 && r.char_byte <= 8'd13)) begin
               bin = BIN_SPACE;
               cls = CLS_SPACE;
            end else begin
               bin = BIN_SPECIAL;
               cls = CLS_OTHER;
            end
            if (have_last) begin
               class_pairs[last_trained * 4 + cls] =
                  saturating_bump(class_pairs[last_trained * 4 + cls]);
               pairs_seen = saturating_bump(pairs_seen);
            end
            letter_bins[bin] = saturating_bump(letter_bins[bin]);
            letters_seen = saturating_bump(letters_seen);
            last_trained = cls;
            have_last = 1'b1;
            res.char_class = cls;
         end
         MODE_START: begin
            for (int i = 0; i < 26; i++) row.push_back(letter_bins[i]);
            k = pick_entry(row, r.rand_a, empty);
            res.out_char = 8'(CHAR_A + k);
            walk_class = letter_is_vowel(k) ? CLS_VOWEL : CLS_CONSONANT;
            res.char_class = walk_class;
         end
         MODE_NEXT: begin
            for (int i = 0; i < 4; i++) row.push_back(class_pairs[walk_class * 4 + i]);
            cls = class_type'(pick_entry(row, r.rand_a, empty));
            row.delete();
            case (cls)
               CLS_CONSONANT: begin
                  for (int i = 0; i < 26; i++)
                     if (!letter_is_vowel(i)) row.push_back(letter_bins[i]);
                  k = pick_entry(row, r.rand_b, empty);
                  for (int i = 0; i < 26; i++)
                     if (!letter_is_vowel(i)) begin
                        if (k == 0) res.out_char = 8'(CHAR_A + i);
                        k--;
                     end
               end
               CLS_VOWEL: begin
                  for (int i = 0; i < 26; i++)
                     if (letter_is_vowel(i)) row.push_back(letter_bins[i]);
                  k = pick_entry(row, r.rand_b, empty);
                  for (int i = 0; i < 26; i++)
                     if (letter_is_vowel(i)) begin
                        if (k == 0) res.out_char = 8'(CHAR_A + i);
                        k--;
                     end
               end
               CLS_SPACE: begin
                  row.push_back(letter_bins[BIN_SPACE]);
                  k = pick_entry(row, r.rand_b, empty);
                  res.out_char = CHAR_SPACE;
               end
               default: begin
                  row.push_back(letter_bins[BIN_SPECIAL]);
                  k = pick_entry(row, r.rand_b, empty);
                  res.out_char = CHAR_HASH;
               end
            endcase
            walk_class = cls;
            res.char_class = cls;
         end
         default: begin
            if (r.read_index < IDX_TRANS) res.count_value = letter_bins[r.read_index];
            else if (r.read_index < IDX_CTOTAL)
               res.count_value = class_pairs[r.read_index - IDX_TRANS];
            else if (r.read_index == IDX_CTOTAL) res.count_value = letters_seen;
            else if (r.read_index == IDX_TTOTAL) res.count_value = pairs_seen;
         end
      endcase
      res.empty_distribution = empty;
      return res;
   endfunction

   // Presents one item after a random idle gap and holds it until accepted.
   // Valid stays high after acceptance so that a following item can go out
   // back to back; an idle gap or a drain drops it.
   task automatic send_item(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(predict_item(r));
      items_sent++;
   endtask

   task automatic send_fields(mode_type m, logic [7:0] b, logic [15:0] ra, logic [15:0] rb,
                              logic [5:0] idx);
      req_type r;
      r.mode = m;
      r.char_byte = b;
      r.rand_a = ra;
      r.rand_b = rb;
      r.read_index = idx;
      send_item(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending_rsps.size() != 0) @(posedge clock);
   endtask

   // A random item, mostly text-like training bytes and generation, with some reads.
   task automatic send_random_item();
      req_type     r;
      int unsigned pick;
      r = req_type'(48'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.mode = MODE_TRAIN;
         case ($urandom_range(5))
            0, 1:    r.char_byte = 8'("a" + $urandom_range(25));
            2:       r.char_byte = 8'("A" + $urandom_range(25));
            3:       r.char_byte = ($urandom_range(1)) ? 8'd32 : 8'(9 + $urandom_range(4));
            default: r.char_byte = 8'($urandom_range(255));
         endcase
      end else if (pick < 55) begin
         r.mode = MODE_START;
      end else if (pick < 85) begin
         r.mode = MODE_NEXT;
      end else begin
         r.mode = MODE_READ;
         if ($urandom_range(9) != 0) r.read_index = 6'($urandom_range(45));
      end
      if ($urandom_range(9) == 0) r.rand_a = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(9) == 0) r.rand_b = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      send_item(r);
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      cycle_count = 0;
      items_sent = 0;
      send_idle_pct = 23;
      recv_idle_pct = 80;
      foreach (letter_bins[i]) letter_bins[i] = '0;
      foreach (class_pairs[i]) class_pairs[i] = '0;
      letters_seen = '0;
      pairs_seen = '0;
      last_trained = CLS_CONSONANT;
      have_last = 1'b0;
      walk_class = CLS_CONSONANT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: generation on empty counters first, including next before start.
      send_fields(MODE_NEXT, 8'h00, 16'h0000, 16'hFFFF, 6'd0);
      send_fields(MODE_START, 8'hFF, 16'hFFFF, 16'h0000, 6'd63);
      send_fields(MODE_READ, 8'h00, 16'h0000, 16'h0000, IDX_CTOTAL);
      // Case folding, y as a vowel, whitespace range ends, high bytes.
      send_fields(MODE_TRAIN, "Z", 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, "y", 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, 8'd9, 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, 8'd13, 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, 8'd32, 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, 8'hFF, 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, 8'h80, 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, "A", 16'h0, 16'h0, 6'd0);
      send_fields(MODE_TRAIN, "b", 16'h0, 16'h0, 6'd0);
      // Zero random takes the first entry even when its count is zero.
      send_fields(MODE_START, 8'h00, 16'h0000, 16'h0000, 6'd0);
      send_fields(MODE_START, 8'h00, 16'hFFFF, 16'hFFFF, 6'd0);
      send_fields(MODE_NEXT, 8'h00, 16'h8000, 16'h0000, 6'd0);
      send_fields(MODE_NEXT, 8'h00, 16'hFFFF, 16'hFFFF, 6'd0);
      send_fields(MODE_NEXT, 8'h00, 16'h0001, 16'h7FFF, 6'd0);
      send_fields(MODE_READ, 8'h00, 16'h0, 16'h0, 6'd25);
      send_fields(MODE_READ, 8'h00, 16'h0, 16'h0, IDX_TRANS);
      send_fields(MODE_READ, 8'h00, 16'h0, 16'h0, 6'd43);
      send_fields(MODE_READ, 8'h00, 16'h0, 16'h0, IDX_TTOTAL);
      send_fields(MODE_READ, 8'hFF, 16'hFFFF, 16'hFFFF, 6'd63);

      // Hold off until the block has answered everything.
      drain_results();

      // Random part in three idling phases.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 23;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_item();
      end

      drain_results();
      repeat (100) @(posedge clock);
      $display("Sent %0d items and checked %0d results across train, start, next and read",
               items_sent, board.checked_count);
      if (board.mismatch_count == 0 && board.pending_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", board.mismatch_count);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
design/ccmts_pkg.sv
design/char_class_markov_trainer_sampler_unit.sv
tb/tb.sv
